FILE: rtl/frwr_pkg.sv
// Shared types and constants for the framed register write receiver.
// Used by the parser, the register file and the top level.
package frwr_pkg;

  localparam int unsigned BufferBytes   = 32;
  localparam int unsigned RegisterCount = 64;
  localparam int unsigned MaxPayload    = BufferBytes - 7;
  localparam int unsigned BufAw         = $clog2(BufferBytes);
  localparam int unsigned RegAw         = $clog2(RegisterCount);

  localparam logic [7:0] HeadFirst    = 8'hAA;
  localparam logic [7:0] HeadSecond   = 8'h55;
  localparam logic [7:0] Broadcast    = 8'h00;
  localparam logic [7:0] WriteCmd     = 8'h02;
  localparam logic [7:0] WritableLow  = 8'h02;
  localparam logic [7:0] WritableHigh = 8'h3F;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_WRITE    = 3'd1,
    ST_OK       = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_HEADER   = 3'd4,
    ST_ADDRESS  = 3'd5,
    ST_LENGTH   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_LOCAL_ADDR  = 2'd0,
    CFG_DEVICE_TYPE = 2'd1,
    CFG_TIMEOUT     = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] start;
    logic [4:0] len;
  } frame_t;

endpackage

FILE: rtl/frwr_if.sv
// Valid/ready channels for input items and result items.
interface frwr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  logic [5:0] read_index;
  modport source (output valid, opcode, rx_byte, read_index, input ready);
  modport sink   (input valid, opcode, rx_byte, read_index, output ready);
endinterface

interface frwr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] frame_address;
  logic [7:0] frame_command;
  logic [7:0] frame_register;
  logic [4:0] frame_length;
  logic [7:0] read_data;
  logic       timed_out;
  modport source (output valid, status, frame_address, frame_command, frame_register,
                  frame_length, read_data, timed_out, input ready);
  modport sink   (input valid, status, frame_address, frame_command, frame_register,
                  frame_length, read_data, timed_out, output ready);
endinterface

FILE: rtl/frwr_regfile.sv
// Register file memory with per-entry valid bits; invalid entries read zero.
// Depends on frwr_pkg.
module frwr_regfile (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [frwr_pkg::RegAw-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic                      wd_clear_i,
  input  logic [frwr_pkg::RegAw-1:0] raddr_i,
  output logic [7:0]                rdata_o
);
  import frwr_pkg::*;

  logic [7:0]               mem [RegisterCount];
  logic [RegisterCount-1:0] vld_q;
  logic [7:0]               rd_q;
  logic                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr_i];
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (wd_clear_i) begin
        vld_q[10] <= 1'b0;
        vld_q[11] <= 1'b0;
        vld_q[14] <= 1'b0;
        vld_q[15] <= 1'b0;
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : 8'h00;

endmodule

FILE: rtl/frwr_parser.sv
// Byte-by-byte frame parser with payload buffer and checksum.
// Depends on frwr_pkg.
module frwr_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [7:0]                 byte_i,
  input  logic [7:0]                 local_addr_i,
  input  logic [frwr_pkg::BufAw-1:0] buf_raddr_i,
  output frwr_pkg::status_e          status_o,
  output frwr_pkg::frame_t           frame_o,
  output logic [7:0]                 buf_rdata_o
);
  import frwr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEAD2, PH_ADDR, PH_CMD, PH_REG, PH_LEN, PH_DATA, PH_SUM
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [BufAw-1:0] cnt_q, cnt_d;
  logic [7:0]      xor_q, xor_d;
  frame_t          frame_q, frame_d;
  logic [7:0]      buf_mem [BufferBytes];
  logic [7:0]      buf_rd_q;
  logic [8:0]      span;
  logic            wr_ok;

  assign span  = {1'b0, frame_q.start} + {4'd0, frame_q.len};
  assign wr_ok = (frame_q.cmd == WriteCmd) && (frame_q.len != 5'd0)
              && (frame_q.start >= WritableLow) && (frame_q.start <= WritableHigh)
              && (span <= 9'(RegisterCount));

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    frame_d  = frame_q;
    status_o = ST_NONE;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == HeadFirst) phase_d = PH_HEAD2;
      end
      PH_HEAD2: begin
        if (byte_i == HeadSecond) begin
          phase_d = PH_ADDR;
        end else if (byte_i != HeadFirst) begin
          phase_d  = PH_HUNT;
          status_o = ST_HEADER;
        end
      end
      PH_ADDR: begin
        if (byte_i != Broadcast && byte_i != local_addr_i) begin
          phase_d  = PH_HUNT;
          status_o = ST_ADDRESS;
        end else begin
          frame_d = '{addr: byte_i, default: '0};
          xor_d   = byte_i;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        frame_d.cmd = byte_i;
        xor_d       = xor_q ^ byte_i;
        phase_d     = PH_REG;
      end
      PH_REG: begin
        frame_d.start = byte_i;
        xor_d         = xor_q ^ byte_i;
        phase_d       = PH_LEN;
      end
      PH_LEN: begin
        if (byte_i > 8'(MaxPayload)) begin
          phase_d  = PH_HUNT;
          status_o = ST_LENGTH;
        end else begin
          frame_d.len = byte_i[4:0];
          xor_d       = xor_q ^ byte_i;
          cnt_d       = '0;
          phase_d     = (byte_i == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        cnt_d = cnt_q + 1'b1;
        xor_d = xor_q ^ byte_i;
        if ({1'b0, cnt_q} + 6'd1 >= {1'b0, frame_q.len}) phase_d = PH_SUM;
      end
      PH_SUM: begin
        phase_d = PH_HUNT;
        if (byte_i != xor_q) status_o = ST_CHECKSUM;
        else                 status_o = wr_ok ? ST_WRITE : ST_OK;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      xor_q   <= '0;
      frame_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && phase_q == PH_DATA) begin
      buf_mem[cnt_q] <= byte_i;
    end
    buf_rd_q <= buf_mem[buf_raddr_i];
  end

  assign frame_o     = frame_q;
  assign buf_rdata_o = buf_rd_q;

endmodule

FILE: rtl/framed_register_write_receiver_top.sv
// Top level: sequencer, watchdog, configuration and result register.
// Depends on frwr_pkg, frwr_if, frwr_parser and frwr_regfile.
//
//   channel | dir | payload
//   in_i    | in  | opcode, rx_byte, read_index
//   out_o   | out | status, frame fields, read_data, timed_out
//
// A byte, tick or read occupies the block through the done state, and its result
// beat is registered as the block leaves that state; a frame that writes first
// loops through the copy read and copy write states once per payload byte, since
// the copy goes through the buffer read port and the single register file write port.
// Reset clears control state and register valid bits at once; no sweep.
// A waiting result holds in the output register; one more item may then be
// accepted and holds in the done state until the register frees.
module framed_register_write_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  frwr_in_if.sink     in_i,
  frwr_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import frwr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CP_RD, S_CP_WR, S_DONE} state_e;

  state_e          state_q;
  logic [7:0]      local_addr_q, dev_type_q;
  logic [15:0]     timeout_q, silence_q;
  logic            expired_q, seen_q;
  status_e         st_q;
  op_e             op_q;
  logic [5:0]      idx_q;
  logic [BufAw-1:0] cnt_q;
  logic            out_valid_q;
  status_e         pstat;
  frame_t          frame;
  logic [7:0]      buf_rdata, rf_rdata, rd_val;
  logic            accept, step, rf_we, wd_clear, tick_trip;
  logic [RegAw-1:0] rf_waddr, rf_raddr;
  logic [15:0]     silence_inc;
  logic [8:0]      waddr_full;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign step = accept && (op_e'(in_i.opcode) == OP_BYTE);

  assign silence_inc = (silence_q < timeout_q) ? silence_q + 16'd1 : silence_q;
  assign tick_trip   = !seen_q && !expired_q && (silence_inc >= timeout_q);
  assign wd_clear    = accept && (op_e'(in_i.opcode) == OP_TICK) && tick_trip;

  assign waddr_full = {1'b0, frame.start} + {4'd0, cnt_q};
  assign rf_waddr   = waddr_full[RegAw-1:0];
  assign rf_we      = (state_q == S_CP_WR);
  assign rf_raddr   = (state_q == S_IDLE) ? in_i.read_index[RegAw-1:0] : idx_q[RegAw-1:0];

  frwr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_i.rx_byte),
    .local_addr_i (local_addr_q),
    .buf_raddr_i  (cnt_q),
    .status_o     (pstat),
    .frame_o      (frame),
    .buf_rdata_o  (buf_rdata)
  );

  frwr_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (rf_we),
    .waddr_i    (rf_waddr),
    .wdata_i    (buf_rdata),
    .wd_clear_i (wd_clear),
    .raddr_i    (rf_raddr),
    .rdata_o    (rf_rdata)
  );

  always_comb begin
    rd_val = 8'h00;
    if (op_q == OP_READ) begin
      if (idx_q == 6'd0)      rd_val = local_addr_q;
      else if (idx_q == 6'd1) rd_val = dev_type_q;
      else                    rd_val = rf_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= 8'd1;
      dev_type_q   <= 8'd16;
      timeout_q    <= 16'd10000;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_LOCAL_ADDR:  local_addr_q <= cfg_data_i[7:0];
        CFG_DEVICE_TYPE: dev_type_q   <= cfg_data_i[7:0];
        CFG_TIMEOUT:     timeout_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      silence_q   <= '0;
      expired_q   <= 1'b0;
      seen_q      <= 1'b0;
      st_q        <= ST_NONE;
      op_q        <= OP_NONE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q  <= op_e'(in_i.opcode);
            idx_q <= in_i.read_index;
            cnt_q <= '0;
            if (op_e'(in_i.opcode) == OP_BYTE) begin
              st_q    <= pstat;
              state_q <= (pstat == ST_WRITE) ? S_CP_RD : S_DONE;
            end else begin
              st_q    <= ST_NONE;
              state_q <= S_DONE;
              if (op_e'(in_i.opcode) == OP_TICK) begin
                if (seen_q) begin
                  seen_q    <= 1'b0;
                  silence_q <= '0;
                  expired_q <= 1'b0;
                end else begin
                  silence_q <= silence_inc;
                  if (tick_trip) expired_q <= 1'b1;
                end
              end
            end
          end
        end
        S_CP_RD: state_q <= S_CP_WR;
        S_CP_WR: begin
          cnt_q <= cnt_q + 1'b1;
          if ({1'b0, cnt_q} + 6'd1 >= {1'b0, frame.len}) begin
            seen_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_CP_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic       good_st;
  logic [2:0] ost_q;
  frame_t     ofr_q;
  logic [7:0] ord_q;
  logic       oto_q;

  assign good_st = (st_q == ST_WRITE) || (st_q == ST_OK);

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
      ost_q <= st_q;
      ofr_q <= good_st ? frame : '0;
      ord_q <= rd_val;
      oto_q <= expired_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = ost_q;
  assign out_o.frame_address  = ofr_q.addr;
  assign out_o.frame_command  = ofr_q.cmd;
  assign out_o.frame_register = ofr_q.start;
  assign out_o.frame_length   = ofr_q.len;
  assign out_o.read_data      = ord_q;
  assign out_o.timed_out      = oto_q;

  a_copy_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (frame.start >= WritableLow) && (cnt_q < frame.len))
    else $error("register write outside frame span");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input ready straight after accepting a beat");

  a_copy_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CP_RD) |-> (st_q == ST_WRITE))
    else $error("payload copy without a write status");

endmodule
